FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the 3x3 convolution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked property, switched off while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked property, checked at every edge including reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

FILE: design/s3c_pkg.sv
// Shared types and constants of the 3x3 convolution block.
`default_nettype none

package s3c_pkg;

    // Field widths
    localparam int PIX_BITS   = 16;
    localparam int COEF_BITS  = 16;
    localparam int PROD_BITS  = PIX_BITS + 1 + COEF_BITS;  // unsigned pixel x signed coef
    localparam int CSUM_BITS  = PROD_BITS + 2;              // sum of three products
    localparam int OUT_BITS   = 36;                         // signed Q12.24
    localparam int ROW_BITS   = 16;
    localparam int LEN_BITS   = 13;
    localparam int CFG_BITS   = 48;
    localparam int WIN_ROWS   = 3;
    localparam int WIN_COLS   = 3;

    // Line geometry
    localparam int LINE_MAX_DEF = 4096;
    localparam int MIN_LINE     = 3;
    localparam int FIRST_INNER  = 2;   // first row / column whose window is interior

    // Register port
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_LSB   = 3;

    typedef enum logic [1:0] {
        REG_COEF_TOP = 2'd0,
        REG_COEF_MID = 2'd1,
        REG_COEF_BOT = 2'd2,
        REG_LINE_LEN = 2'd3
    } t_reg_idx;

    // One window column: [0] oldest row, [2] newest row
    typedef logic [WIN_ROWS-1:0][PIX_BITS-1:0]  t_pix_col;
    // Coefficients of one window column, same row order
    typedef logic [WIN_ROWS-1:0][COEF_BITS-1:0] t_coef_col;

    // Pipeline controls shared by all cells
    typedef struct packed {
        logic shift;  // a new column enters the window
        logic adv;    // the arithmetic stages move forward
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/s3c_cell.sv
// One window column cell: holds three samples, multiplies and sums its column.
`default_nettype none

module s3c_cell import s3c_pkg::*; (
    input  wire logic                        i_clk,
    input  wire t_cell_ctl                   i_ctl,
    input  wire t_pix_col                    i_col,
    input  wire t_coef_col                   i_coef,
    output t_pix_col                         o_col,
    output logic signed [CSUM_BITS-1:0]      o_sum
);

    t_pix_col                     r_win;
    logic signed [PROD_BITS-1:0]  r_prod [WIN_ROWS];
    logic signed [CSUM_BITS-1:0]  r_sum;

    // Window column, handed to the older neighbor on each shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= i_col;
        end
    end

    // Products, one multiplier per row
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            for (int r = 0; r < WIN_ROWS; r++) begin
                r_prod[r] <= $signed({1'b0, r_win[r]}) * $signed(i_coef[r]);
            end
        end
    end

    // Column sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_sum <= CSUM_BITS'(r_prod[0]) + CSUM_BITS'(r_prod[1]) + CSUM_BITS'(r_prod[2]);
        end
    end

    assign o_col = r_win;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

FILE: design/stencil_3x3_convolution.sv
// 3x3 convolution over a raster sample stream, top level.
//
// Input channel: one unsigned Q0.16 sample per item, tuser marks the first
// sample of a frame (row and column restart at zero). Output channel: one
// item per interior position, carrying the signed Q12.24 weighted sum, the
// window centre's row and column, and tlast on the last result of a row.
// Border positions give no output item.
// Registers (APB, 64-bit data, byte address 8*index): three coefficient rows
// of three signed Q8.8 values each, and the line length (saturated to
// 3..LINE_MAX). Write them only while the stream is idle.
// Throughput: one item per clock while the receiver does not stall. Each
// result is registered in turn: line buffer read at the edge that accepts
// its sample, then window shift, multiply, column sum, final sum.
// Reset clears counters, valid bits and coefficients and sets the line length to
// LINE_MAX_DEF; line buffer contents are not cleared, so a row longer than the
// previous one must start a new frame. While the receiver stalls a valid result,
// the whole pipeline holds and the input ready goes low; it stays low during reset.
`default_nettype none
`include "assert_macros.svh"

module stencil_3x3_convolution import s3c_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF,
    localparam int COL_W   = $clog2(LINE_MAX),
    localparam int OUT_W   = ((OUT_BITS + ROW_BITS + COL_W + 7) / 8) * 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Sample input
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [PIX_BITS-1:0]        i_s_axis_tdata,  // [15:0] pixel
    input  wire logic                       i_s_axis_tuser,  // [0] frame_start
    // Result output
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [OUT_W-1:0]                o_m_axis_tdata,  // filtered, out_row, out_col, zero pad
    output logic                            o_m_axis_tlast,  // row_end
    // Register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [APB_DATA_BITS-1:0]   pwdata,
    output logic [APB_DATA_BITS-1:0]        prdata,
    output logic                            pready
);

    localparam int LEN_CMP_W = (COL_W + 1 > LEN_BITS) ? COL_W + 1 : LEN_BITS;
    localparam logic [LEN_CMP_W-1:0] LEN_HI = LEN_CMP_W'(LINE_MAX);
    localparam logic [LEN_CMP_W-1:0] LEN_LO = LEN_CMP_W'(MIN_LINE);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [CFG_BITS-1:0] r_coef_top, r_coef_mid, r_coef_bot;
    logic [LEN_BITS-1:0] r_line_len;
    t_reg_idx            reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:REG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
            r_line_len <= LEN_BITS'(LINE_MAX_DEF);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COEF_TOP: r_coef_top <= pwdata[CFG_BITS-1:0];
                REG_COEF_MID: r_coef_mid <= pwdata[CFG_BITS-1:0];
                REG_COEF_BOT: r_coef_bot <= pwdata[CFG_BITS-1:0];
                REG_LINE_LEN: r_line_len <= pwdata[LEN_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COEF_TOP: prdata = APB_DATA_BITS'(r_coef_top);
            REG_COEF_MID: prdata = APB_DATA_BITS'(r_coef_mid);
            REG_COEF_BOT: prdata = APB_DATA_BITS'(r_coef_bot);
            REG_LINE_LEN: prdata = APB_DATA_BITS'(r_line_len);
        endcase
    end

    // Line length in use, held to the supported range
    logic [LEN_CMP_W-1:0] len_raw, len_act;
    assign len_raw = LEN_CMP_W'(r_line_len);
    always_comb begin
        priority if (len_raw < LEN_LO) len_act = LEN_LO;
        else if (len_raw > LEN_HI)     len_act = LEN_HI;
        else                           len_act = len_raw;
    end

    // ---------------------------------------------------------------
    // Flow control: every stage moves when the output register is free
    // ---------------------------------------------------------------
    logic r_run;
    logic r_out_valid;
    logic adv, accept;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = i_rst_n && r_run && adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_run <= 1'b0;
        else          r_run <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Raster position
    // ---------------------------------------------------------------
    logic [COL_W-1:0]    r_col;
    logic [ROW_BITS-1:0] r_row;
    logic [COL_W-1:0]    col_eff;
    logic [ROW_BITS-1:0] row_eff;
    logic                row_last, emit;

    assign col_eff  = i_s_axis_tuser ? '0 : r_col;
    assign row_eff  = i_s_axis_tuser ? '0 : r_row;
    assign row_last = (LEN_CMP_W'(col_eff) + LEN_CMP_W'(1)) >= len_act;
    assign emit     = (row_eff >= ROW_BITS'(FIRST_INNER)) && (col_eff >= COL_W'(FIRST_INNER));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_last) begin
                r_col <= '0;
                r_row <= row_eff + ROW_BITS'(1);
            end else begin
                r_col <= col_eff + COL_W'(1);
                r_row <= row_eff;
            end
        end
    end

    // ---------------------------------------------------------------
    // Line buffers: middle written with the new sample, upper written in the
    // next cycle with the middle entry that was read out
    // ---------------------------------------------------------------
    logic [PIX_BITS-1:0] mem_upper  [LINE_MAX];
    logic [PIX_BITS-1:0] mem_middle [LINE_MAX];
    logic [PIX_BITS-1:0] r_b_top, r_b_mid, r_b_px;
    logic                r_uw_en;
    logic [COL_W-1:0]    r_uw_addr;
    logic                uw_fwd;

    assign uw_fwd = r_uw_en && (r_uw_addr == col_eff);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_middle[col_eff] <= i_s_axis_tdata;
            r_b_mid             <= mem_middle[col_eff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_uw_en) begin
            mem_upper[r_uw_addr] <= r_b_mid;
        end
        if (accept) begin
            r_b_top <= uw_fwd ? r_b_mid : mem_upper[col_eff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uw_en   <= 1'b0;
            r_uw_addr <= '0;
        end else begin
            r_uw_en   <= accept;
            r_uw_addr <= col_eff;
        end
    end

    // ---------------------------------------------------------------
    // Stage valid bits and result tags
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_W-1:0]    col;
        logic                last;
    } t_tag;

    logic r_vb, r_b_emit, r_vc, r_vd, r_ve;
    t_tag r_b_tag, r_c_tag, r_d_tag, r_e_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (adv) begin
            r_vb <= accept;
            r_vc <= r_vb && r_b_emit;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (accept) begin
                r_b_px       <= i_s_axis_tdata;
                r_b_emit     <= emit;
                r_b_tag.row  <= row_eff - ROW_BITS'(1);
                r_b_tag.col  <= col_eff - COL_W'(1);
                r_b_tag.last <= row_last;
            end
            r_c_tag <= r_b_tag;
            r_d_tag <= r_c_tag;
            r_e_tag <= r_d_tag;
        end
    end

    // ---------------------------------------------------------------
    // Chain of window column cells: cell 2 takes the newest column and
    // hands it on toward cell 0 on each shift
    // ---------------------------------------------------------------
    t_cell_ctl                    cell_ctl;
    t_pix_col                     cell_in  [WIN_COLS];
    t_pix_col                     cell_out [WIN_COLS];
    t_coef_col                    cell_coef[WIN_COLS];
    logic signed [CSUM_BITS-1:0]  col_sum  [WIN_COLS];

    assign cell_ctl = '{shift: adv && r_vb, adv: adv};

    for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
        if (k == WIN_COLS - 1) begin : g_head
            assign cell_in[k] = {r_b_px, r_b_mid, r_b_top};
        end else begin : g_link
            assign cell_in[k] = cell_out[k+1];
        end
        assign cell_coef[k] = {r_coef_bot[k*COEF_BITS +: COEF_BITS],
                               r_coef_mid[k*COEF_BITS +: COEF_BITS],
                               r_coef_top[k*COEF_BITS +: COEF_BITS]};

        s3c_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_col  (cell_in[k]),
            .i_coef (cell_coef[k]),
            .o_col  (cell_out[k]),
            .o_sum  (col_sum[k])
        );
    end

    // ---------------------------------------------------------------
    // Output register: final sum of the three column sums
    // ---------------------------------------------------------------
    logic signed [OUT_BITS-1:0] r_out_sum;
    t_tag                       r_out_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_ve) begin
            r_out_sum <= OUT_BITS'(col_sum[0]) + OUT_BITS'(col_sum[1]) + OUT_BITS'(col_sum[2]);
            r_out_tag <= r_e_tag;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_tag.col, r_out_tag.row, r_out_sum});
    assign o_m_axis_tlast  = r_out_tag.last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_CLK(a_no_accept_in_reset, i_clk,
        !i_rst_n |-> !o_s_axis_tready, "sample accepted during reset")
    `ASSERT_CLK_RST(a_stall_blocks_input, i_clk, i_rst_n,
        (r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready,
        "input taken while result stalled")
    `ASSERT_CLK_RST(a_result_interior, i_clk, i_rst_n,
        r_out_valid |-> (r_out_tag.row != '0 && r_out_tag.col != '0),
        "result tagged with a border position")
    `ASSERT_CLK_RST(a_stage_holds, i_clk, i_rst_n,
        (r_ve && !adv) |=> r_ve, "final stage lost its item during a stall")

endmodule

`default_nettype wire
